### rtl/datagram_frame_reassembler_unit_macros.svh
// Assertion macros shared by the reassembler's RTL files.
`ifndef DATAGRAM_FRAME_REASSEMBLER_UNIT_MACROS_SVH
`define DATAGRAM_FRAME_REASSEMBLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DFR_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`else
`define DFR_ASSERT(lbl, prop, msg)
`define DFR_CHECK(lbl, cond, msg)
`endif
`endif

### rtl/dfr_pkg.sv
package dfr_pkg;

	localparam int FRAME_BYTES  = 1048576;
	localparam int BUFFER_SLOTS = 3;
	localparam int HEADER_BYTES = 9;

	localparam int LEN_W    = 21;
	localparam int ADDR_W   = 20;
	localparam int SLOT_W   = 2;
	localparam int CNT_W    = 16;
	localparam int POS_W    = 4;
	localparam int SAT_IN_W = 34;

	// Header position at which payload bytes begin.
	localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HEADER_BYTES);

	// Depth of the queue between the parser and the result stage.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		EV_WRITE    = 2'd0,
		EV_COMPLETE = 2'd1,
		EV_REJECT   = 2'd2,
		EV_ABANDON  = 2'd3
	} dfr_event_t;

	// One classified input byte: up to one early result (write or abandon)
	// and one end-of-datagram result, plus the header needed for the length.
	typedef struct packed {
		logic              a_v;
		dfr_event_t        a_ev;
		logic              b_v;
		dfr_event_t        b_ev;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic [CNT_W-1:0]  a_seen;
		logic [CNT_W-1:0]  b_seen;
		logic [15:0]       ps;
		logic [15:0]       ft;
		logic [15:0]       ts;
	} dfr_entry_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [SAT_IN_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v > SAT_IN_W'(FRAME_BYTES)) begin
			r = LEN_W'(FRAME_BYTES);
		end else begin
			r = v[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/dfr_queue.sv
`include "datagram_frame_reassembler_unit_macros.svh"

module dfr_queue
	import dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  dfr_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output dfr_entry_t pop_data,
	output logic       empty
);

	dfr_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`DFR_ASSERT(a_no_overflow, push |-> !full, "queue written while full")
	`DFR_ASSERT(a_no_underflow, pop |-> !empty, "queue read while empty")
	`DFR_ASSERT(a_cnt_hold, !(push ^ pop) |=> cnt_q == $past(cnt_q), "queue count drifted")

endmodule

### rtl/dfr_front.sv
module dfr_front
	import dfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       datagram_end,
	input  logic       q_full,
	output logic       q_push,
	output dfr_entry_t q_data
);

	logic [POS_W-1:0]  pos_q, pos_n;
	logic [7:0]        id_q, id_n;
	logic [15:0]       ps_q, ps_n;
	logic [15:0]       ft_q, ft_n;
	logic [15:0]       ts_q, ts_n;
	logic [CNT_W-1:0]  frags_q, frags_n;
	logic [LEN_W-1:0]  wptr_q, wptr_n;
	logic [LEN_W-1:0]  wend_q, wend_n;
	logic              newf_q, newf_n;
	logic              reject_q, reject_n;
	logic              prevc_q, prevc_n;
	logic [SLOT_W-1:0] slot_q, slot_n;

	logic [15:0]       chunk_q;
	logic [7:0]        idx_hi_q;
	logic [23:0]       hi_prod_q;

	logic              accept;
	logic [1:0]        fsel;
	logic [15:0]       fcur;
	logic [15:0]       fnew;
	logic [7:0]        fexp;
	logic [23:0]       lo_prod;
	logic [SAT_IN_W-1:0] start_raw;
	logic [SAT_IN_W-1:0] end_raw;
	logic [15:0]       index;
	logic [15:0]       span;
	logic [CNT_W-1:0]  frags_inc;
	dfr_entry_t        ent;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Fragment index is known in two halves; the high byte's product is
	// formed one byte early so the start offset costs one small multiply.
	assign index     = {idx_hi_q, data_byte};
	assign lo_prod   = 24'(data_byte) * 24'(chunk_q);
	assign start_raw = SAT_IN_W'({hi_prod_q, 8'h00}) + SAT_IN_W'(lo_prod);
	assign span      = ((17'(index) + 17'd1 == 17'(ft_q)) && (ts_q != '0)) ? ts_q : chunk_q;
	assign end_raw   = start_raw + SAT_IN_W'(span);

	always_comb begin
		fsel = 2'd2;
		if (pos_q inside {[4'd1:4'd2]}) begin
			fsel = 2'd0;
		end else if (pos_q inside {[4'd3:4'd4]}) begin
			fsel = 2'd1;
		end
		case (fsel)
			2'd0:    fcur = ps_q;
			2'd1:    fcur = ft_q;
			default: fcur = ts_q;
		endcase
		fnew = {fcur[7:0], data_byte};
		fexp = pos_q[0] ? fcur[15:8] : fcur[7:0];
	end

	always_comb begin
		pos_n     = pos_q;
		id_n      = id_q;
		ps_n      = ps_q;
		ft_n      = ft_q;
		ts_n      = ts_q;
		frags_n   = frags_q;
		wptr_n    = wptr_q;
		wend_n    = wend_q;
		newf_n    = newf_q;
		reject_n  = reject_q;
		prevc_n   = prevc_q;
		slot_n    = slot_q;
		frags_inc = '0;
		ent       = '0;
		ent.a_ev  = EV_WRITE;
		ent.b_ev  = EV_REJECT;
		ent.slot  = slot_q;
		ent.a_seen = frags_q;

		if (pos_q == '0) begin
			reject_n = 1'b0;
			if (data_byte != id_q) begin
				if (!prevc_q) begin
					ent.a_v  = 1'b1;
					ent.a_ev = EV_ABANDON;
				end
				prevc_n = 1'b0;
				id_n    = data_byte;
				newf_n  = 1'b1;
				frags_n = '0;
			end else begin
				newf_n = 1'b0;
			end
			pos_n = pos_q + POS_W'(1);
		end else if (pos_q inside {[4'd1:4'd6]}) begin
			if (newf_q) begin
				case (fsel)
					2'd0:    ps_n = fnew;
					2'd1:    ft_n = fnew;
					default: ts_n = fnew;
				endcase
			end else if (fexp != data_byte) begin
				reject_n = 1'b1;
			end
			pos_n = pos_q + POS_W'(1);
		end else if (pos_q == 4'd7) begin
			pos_n = pos_q + POS_W'(1);
		end else if (pos_q == 4'd8) begin
			wptr_n = sat_len(start_raw);
			wend_n = sat_len(end_raw);
			pos_n  = POS_PAYLOAD;
		end else begin
			if (!reject_q && (wptr_q < wend_q)) begin
				ent.a_v  = 1'b1;
				ent.a_ev = EV_WRITE;
				ent.addr = wptr_q[ADDR_W-1:0];
				ent.data = data_byte;
				wptr_n   = wptr_q + LEN_W'(1);
			end
		end

		if (datagram_end) begin
			if (reject_n || (pos_n < POS_PAYLOAD) || (wptr_n < wend_n)) begin
				ent.b_v    = 1'b1;
				ent.b_ev   = EV_REJECT;
				ent.b_seen = frags_n;
			end else begin
				frags_inc = frags_n + CNT_W'(1);
				frags_n   = frags_inc;
				if (frags_inc == ft_n) begin
					prevc_n    = 1'b1;
					ent.b_v    = 1'b1;
					ent.b_ev   = EV_COMPLETE;
					ent.b_seen = frags_inc;
					slot_n     = (slot_q == SLOT_W'(BUFFER_SLOTS - 1)) ?
						'0 : slot_q + SLOT_W'(1);
				end
			end
			pos_n    = '0;
			reject_n = 1'b0;
		end

		ent.ps = ps_n;
		ent.ft = ft_n;
		ent.ts = ts_n;
	end

	assign q_push = accept && (ent.a_v || ent.b_v);
	assign q_data = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			id_q     <= '0;
			ps_q     <= '0;
			ft_q     <= '0;
			ts_q     <= '0;
			frags_q  <= '0;
			wptr_q   <= '0;
			wend_q   <= '0;
			newf_q   <= 1'b0;
			reject_q <= 1'b0;
			prevc_q  <= 1'b1;
			slot_q   <= '0;
		end else if (accept) begin
			pos_q    <= pos_n;
			id_q     <= id_n;
			ps_q     <= ps_n;
			ft_q     <= ft_n;
			ts_q     <= ts_n;
			frags_q  <= frags_n;
			wptr_q   <= wptr_n;
			wend_q   <= wend_n;
			newf_q   <= newf_n;
			reject_q <= reject_n;
			prevc_q  <= prevc_n;
			slot_q   <= slot_n;
		end
	end

	// The payload size is registered from the packet size, well before the
	// fragment index arrives.
	always_ff @(posedge clk) begin
		chunk_q <= (ps_q >= 16'(HEADER_BYTES)) ? ps_q - 16'(HEADER_BYTES) : '0;
		if (accept && (pos_q == 4'd7)) begin
			idx_hi_q  <= data_byte;
			hi_prod_q <= 24'(data_byte) * 24'(chunk_q);
		end
	end

endmodule

### rtl/dfr_back.sv
`include "datagram_frame_reassembler_unit_macros.svh"

module dfr_back
	import dfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  dfr_entry_t        q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        event_res,
	output logic [SLOT_W-1:0] buffer_slot,
	output logic [ADDR_W-1:0] byte_address,
	output logic [7:0]        payload_byte,
	output logic [LEN_W-1:0]  frame_length,
	output logic [CNT_W-1:0]  fragments_seen,
	output logic              run_last
);

	logic             v_s1, v_s2, v_s3;
	dfr_entry_t       e_s1, e_s2, e_s3;
	logic [15:0]      chunk_s1;
	logic [15:0]      mul_a_s1;
	logic             zero_s1, zero_s2;
	logic [31:0]      prod_s2;
	logic [LEN_W-1:0] len_s3;

	logic             job_v_q;
	dfr_entry_t       job_q;
	logic [LEN_W-1:0] len_q;
	logic             phase_b_q;

	logic             rdy1, rdy2, rdy3;
	logic             out_accept;
	logic             last_result;
	logic             load_ok;
	logic             a_keep;
	logic [32:0]      len_sum;

	assign out_accept  = job_v_q && !out_stall;
	assign last_result = phase_b_q || !job_q.b_v;
	assign load_ok     = !job_v_q || (out_accept && last_result);

	assign rdy3  = !v_s3 || load_ok;
	assign rdy2  = !v_s2 || rdy3;
	assign rdy1  = !v_s1 || rdy2;
	assign q_pop = !q_empty && rdy1;

	// Writes at or past the frame length are dropped here.
	assign a_keep  = e_s3.a_v &&
		((e_s3.a_ev != EV_WRITE) || (LEN_W'(e_s3.addr) < len_s3));
	assign len_sum = 33'(prod_s2) + 33'(e_s2.ts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			job_v_q   <= 1'b0;
			phase_b_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= q_pop;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (load_ok) begin
				job_v_q   <= v_s3 && (a_keep || e_s3.b_v);
				phase_b_q <= !a_keep;
			end else if (out_accept) begin
				phase_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			e_s1     <= q_data;
			chunk_s1 <= (q_data.ps >= 16'(HEADER_BYTES)) ?
				q_data.ps - 16'(HEADER_BYTES) : '0;
			mul_a_s1 <= (q_data.ts == '0) ? q_data.ft : q_data.ft - 16'd1;
			zero_s1  <= (q_data.ft == '0);
		end
		if (rdy2) begin
			e_s2    <= e_s1;
			zero_s2 <= zero_s1;
			prod_s2 <= 32'(mul_a_s1) * 32'(chunk_s1);
		end
		if (rdy3) begin
			e_s3   <= e_s2;
			len_s3 <= zero_s2 ? '0 : sat_len(SAT_IN_W'(len_sum));
		end
		if (load_ok) begin
			job_q <= e_s3;
			len_q <= len_s3;
		end
	end

	assign out_valid      = job_v_q;
	assign event_res      = phase_b_q ? job_q.b_ev : job_q.a_ev;
	assign buffer_slot    = job_q.slot;
	assign byte_address   = phase_b_q ? '0 : job_q.addr;
	assign payload_byte   = phase_b_q ? '0 : job_q.data;
	assign frame_length   = len_q;
	assign fragments_seen = phase_b_q ? job_q.b_seen : job_q.a_seen;
	assign run_last       = last_result;

	`DFR_ASSERT(a_write_in_range, out_valid && event_res == EV_WRITE |-> LEN_W'(byte_address) < frame_length, "payload write past frame length")
	`DFR_ASSERT(a_complete_last, out_valid && event_res == EV_COMPLETE |-> run_last, "frame complete is not the last result of its byte")
	`DFR_ASSERT(a_second_present, job_v_q && phase_b_q |-> job_q.b_v, "second result shown without one queued")

endmodule

### rtl/datagram_frame_reassembler_unit.sv
// Channel | Side   | Handshake          | Fields
// input   | sink   | in_valid/in_stall  | data_byte, datagram_end
// output  | source | out_valid/out_stall| event_res, buffer_slot, byte_address,
//         |        |                    | payload_byte, frame_length,
//         |        |                    | fragments_seen, run_last
//
// One byte request is taken per cycle while the four-entry queue has room.
// A request yields zero, one or two results; results leave one per cycle while
// out_stall is low, so a byte that closes a datagram after a payload write
// yields two results, and the queue absorbs that against idle header bytes.
// An accepted byte's first result passes through the queue, the three stages
// of the frame-length pipeline and the output register. The queue is written
// at the accepting edge itself.
// arst_n clears all control state asynchronously; the parser restarts awaiting
// a frame id byte, with the previous frame counted as complete.
// in_stall is high exactly when the queue is full; out_stall holds the output
// register and, once they fill, the length pipeline and queue behind it.

module datagram_frame_reassembler_unit
	import dfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        datagram_end,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [1:0]  buffer_slot,
	output logic [19:0] byte_address,
	output logic [7:0]  payload_byte,
	output logic [20:0] frame_length,
	output logic [15:0] fragments_seen,
	output logic        run_last
);

	// The front parses the 9-byte header, tracks the fragment span and the
	// frame bookkeeping, and turns each byte into one queue entry when it
	// causes any result. Entries carry the header snapshot so the back can
	// work out the frame length on its own, independent of later bytes.
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	dfr_entry_t q_wdata;
	dfr_entry_t q_rdata;

	dfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.datagram_end (datagram_end),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	// The queue lets the parser keep taking bytes while the output is held, until it is full.
	dfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// The back computes the frame length, drops writes beyond it, and shows
	// the entry's results one after the other with run_last on the final one.
	dfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.buffer_slot    (buffer_slot),
		.byte_address   (byte_address),
		.payload_byte   (payload_byte),
		.frame_length   (frame_length),
		.fragments_seen (fragments_seen),
		.run_last       (run_last)
	);

endmodule
